FILE: rtl/cdbc_pkg.sv
// Shared types and constants for the column duty-cycle and boost controller.
// No dependencies; imported by every module of the block.
package cdbc_pkg;

    localparam int DUTY_W     = 16;   // Q1.15 duty cycles
    localparam int ALPHA_W    = 16;   // Q0.16 weights and thresholds
    localparam int BOOST_W    = 16;   // Q4.12 boost
    localparam int RATE_W     = 12;   // Q0.12 boost step
    localparam int STEP_W     = 32;
    localparam int MINOV_W    = 10;
    localparam int PROD_W     = DUTY_W + ALPHA_W;
    localparam int EMA_ACC_W  = 34;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [DUTY_W-1:0]    DUTY_ONE   = 16'h8000;
    localparam logic [BOOST_W-1:0]   BOOST_ONE  = 16'h1000;
    localparam logic [ALPHA_W:0]     ALPHA_ONE  = 17'h10000;
    localparam logic [EMA_ACC_W-1:0] EMA_ROUND  = 34'h0_0000_8000;

    localparam logic [ALPHA_W-1:0] EMA_ALPHA_RST  = 16'd655;
    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RST = 16'd6554;
    localparam logic [ALPHA_W-1:0] INC_THR_RST    = 16'd6554;
    localparam logic [ALPHA_W-1:0] DEC_THR_RST    = 16'd32768;
    localparam logic [RATE_W-1:0]  BOOST_RATE_RST = 12'd41;
    localparam logic [BOOST_W-1:0] MIN_BOOST_RST  = 16'd4096;
    localparam logic [BOOST_W-1:0] MAX_BOOST_RST  = 16'd0;
    localparam logic [MINOV_W-1:0] MIN_OVL_RST    = 10'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EMA_ALPHA      = 3'd0,
        REG_FAST_EMA_ALPHA = 3'd1,
        REG_INC_THRESHOLD  = 3'd2,
        REG_DEC_THRESHOLD  = 3'd3,
        REG_BOOST_RATE     = 3'd4,
        REG_MIN_BOOST      = 3'd5,
        REG_MAX_BOOST      = 3'd6,
        REG_MIN_OVERLAP    = 3'd7
    } cdbc_reg_idx_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] ema_alpha;
        logic [ALPHA_W-1:0] fast_ema_alpha;
        logic [ALPHA_W-1:0] increase_threshold;
        logic [ALPHA_W-1:0] decrease_threshold;
        logic [RATE_W-1:0]  boost_rate;
        logic [BOOST_W-1:0] min_boost;
        logic [BOOST_W-1:0] max_boost;
        logic [MINOV_W-1:0] min_overlap;
    } cdbc_cfg_t;

    typedef struct packed {
        logic clamp;
        logic nudge;
    } cdbc_flags_t;

endpackage

FILE: rtl/cdbc_ema.sv
// One exponential moving average step on a Q1.15 duty cycle, rounded half up.
// Depends on cdbc_pkg.
module cdbc_ema import cdbc_pkg::*; (
    input  logic [DUTY_W-1:0]  old_duty,
    input  logic [ALPHA_W-1:0] alpha,
    input  logic               hit,
    output logic [DUTY_W-1:0]  new_duty
);

    logic [ALPHA_W:0]         keep_w;
    logic [EMA_ACC_W-1:0]     acc;
    logic [EMA_ACC_W-17:0]    scaled;

    always_comb begin
        keep_w = ALPHA_ONE - {1'b0, alpha};
        acc    = EMA_ACC_W'(keep_w) * EMA_ACC_W'(old_duty)
               + (hit ? (EMA_ACC_W'(alpha) << 15) : '0)
               + EMA_ROUND;
        scaled = acc[EMA_ACC_W-1:16];
        // saturate to the field width
        new_duty = (|scaled[EMA_ACC_W-17:DUTY_W]) ? '1 : scaled[DUTY_W-1:0];
    end

endmodule

FILE: rtl/cdbc_boost.sv
// Boost rise/fall decision and permanence-request flags for one time step.
// Depends on cdbc_pkg.
module cdbc_boost import cdbc_pkg::*; (
    input  cdbc_cfg_t          cfg,
    input  logic [BOOST_W-1:0] boost_old,
    input  logic [STEP_W-1:0]  last_step_old,
    input  logic [STEP_W-1:0]  step,
    input  logic [DUTY_W-1:0]  slow_new,
    input  logic [DUTY_W-1:0]  fast_new,
    input  logic [PROD_W-1:0]  inc_prod,
    input  logic [PROD_W-1:0]  dec_prod,
    output logic [BOOST_W-1:0] boost_new,
    output logic [STEP_W-1:0]  last_step_new,
    output cdbc_flags_t        flags
);

    logic [PROD_W-1:0]  slow_sh;
    logic [PROD_W-1:0]  fast_sh;
    logic               rise;
    logic               below_cap;
    logic               fall;
    logic [BOOST_W:0]   sum;
    logic [BOOST_W-1:0] sum_sat;
    logic [BOOST_W-1:0] raised;
    logic [BOOST_W-1:0] rate_ext;
    logic [BOOST_W-1:0] nb;
    logic [BOOST_W-1:0] lowered;
    logic [STEP_W-1:0]  step_m1;

    always_comb begin
        slow_sh   = {slow_new, {(PROD_W-DUTY_W){1'b0}}};
        fast_sh   = {fast_new, {(PROD_W-DUTY_W){1'b0}}};
        rise      = slow_sh < inc_prod;
        below_cap = (cfg.max_boost == '0) || (boost_old < cfg.max_boost);
        rate_ext  = BOOST_W'(cfg.boost_rate);

        sum     = {1'b0, boost_old} + {1'b0, rate_ext};
        sum_sat = sum[BOOST_W] ? '1 : sum[BOOST_W-1:0];
        raised  = ((cfg.max_boost != '0) && (sum_sat > cfg.max_boost)) ? cfg.max_boost
                                                                        : sum_sat;

        nb      = (boost_old >= rate_ext) ? (boost_old - rate_ext) : '0;
        lowered = (nb > cfg.min_boost) ? nb : cfg.min_boost;
        fall    = (boost_old > cfg.min_boost) && (slow_sh > dec_prod) && (fast_sh > dec_prod);

        step_m1 = step - STEP_W'(1);

        boost_new     = boost_old;
        last_step_new = last_step_old;
        flags         = '0;
        if (rise) begin
            if (below_cap) begin
                // new boost period when the previous step did not boost
                flags.clamp   = (step != '0) && (last_step_old < step_m1);
                boost_new     = raised;
                last_step_new = step;
            end else begin
                flags.nudge = 1'b1;
            end
        end else if (fall) begin
            boost_new = lowered;
        end
    end

endmodule

FILE: rtl/column_duty_cycle_boost_controller.sv
// Column duty-cycle and boost controller, one time step per beat.
// An accepted beat passes through the input stage register, then the result stage register;
// throughput 1 beat per cycle while the result side is not stalled, set by the single pass from the input
// stage register through the EMA/boost logic into the result stage.
// Reset (aresetn low, synchronous): duties 1.0, boost 1.0, last boost step 0,
// configuration registers to defaults, both pipeline stages emptied.
module column_duty_cycle_boost_controller import cdbc_pkg::*; #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // input channel
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_column_active,
    input  logic [DUTY_W-1:0]      s_max_neighbor_duty,
    input  logic [STEP_W-1:0]      s_step_count,
    input  logic [COUNT_WIDTH-1:0] s_active_connected_count,
    input  logic [COUNT_WIDTH-1:0] s_inactive_strong_count,
    // result channel
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [DUTY_W-1:0]      m_active_duty,
    output logic [DUTY_W-1:0]      m_fast_active_duty,
    output logic [DUTY_W-1:0]      m_overlap_duty,
    output logic [BOOST_W-1:0]     m_boost_value,
    output logic                   m_clamp_connected,
    output logic                   m_nudge_permanences
);

    localparam int OVL_W    = 2 * COUNT_WIDTH + 1;
    localparam int MO_EXT_W = COUNT_WIDTH + MINOV_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    cdbc_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ema_alpha          <= EMA_ALPHA_RST;
            cfg_reg.fast_ema_alpha     <= FAST_ALPHA_RST;
            cfg_reg.increase_threshold <= INC_THR_RST;
            cfg_reg.decrease_threshold <= DEC_THR_RST;
            cfg_reg.boost_rate         <= BOOST_RATE_RST;
            cfg_reg.min_boost          <= MIN_BOOST_RST;
            cfg_reg.max_boost          <= MAX_BOOST_RST;
            cfg_reg.min_overlap        <= MIN_OVL_RST;
        end else if (cfg_we) begin
            unique case (cdbc_reg_idx_t'(cfg_index))
                REG_EMA_ALPHA:      cfg_reg.ema_alpha          <= cfg_wdata[ALPHA_W-1:0];
                REG_FAST_EMA_ALPHA: cfg_reg.fast_ema_alpha     <= cfg_wdata[ALPHA_W-1:0];
                REG_INC_THRESHOLD:  cfg_reg.increase_threshold <= cfg_wdata[ALPHA_W-1:0];
                REG_DEC_THRESHOLD:  cfg_reg.decrease_threshold <= cfg_wdata[ALPHA_W-1:0];
                REG_BOOST_RATE:     cfg_reg.boost_rate         <= cfg_wdata[RATE_W-1:0];
                REG_MIN_BOOST:      cfg_reg.min_boost          <= cfg_wdata[BOOST_W-1:0];
                REG_MAX_BOOST:      cfg_reg.max_boost          <= cfg_wdata[BOOST_W-1:0];
                REG_MIN_OVERLAP:    cfg_reg.min_overlap        <= cfg_wdata[MINOV_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: two stages, input stage and result stage. The result
    // stage frees when the downstream takes its beat; the input stage
    // moves forward whenever the result stage is free.
    // ------------------------------------------------------------------
    logic in_vld_reg;
    logic in_vld_next;
    logic m_valid_reg;
    logic m_valid_next;
    logic out_free;
    logic load_in;
    logic move;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !in_vld_reg || out_free;
    assign load_in  = s_valid && s_ready;
    assign move     = in_vld_reg && out_free;

    always_comb begin
        in_vld_next  = load_in || (in_vld_reg && !move);
        m_valid_next = move || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Input stage: overlap test and neighbor-duty threshold products are
    // computed on the incoming beat and captured with it.
    // ------------------------------------------------------------------
    logic [MO_EXT_W-1:0]    mo_ext;
    logic [COUNT_WIDTH-1:0] min_ov;
    logic [OVL_W-1:0]       ac_sq;
    logic [OVL_W-1:0]       mo_span;
    logic                   met;

    always_comb begin
        // mask min_overlap to the count width
        mo_ext  = MO_EXT_W'(cfg_reg.min_overlap);
        min_ov  = mo_ext[COUNT_WIDTH-1:0];
        ac_sq   = OVL_W'(s_active_connected_count) * OVL_W'(s_active_connected_count);
        mo_span = OVL_W'(min_ov) * (OVL_W'(s_active_connected_count)
                                  + OVL_W'(s_inactive_strong_count));
        met     = (s_active_connected_count >= min_ov) && (ac_sq >= mo_span);
    end

    logic              in_active_reg;
    logic              in_met_reg;
    logic [STEP_W-1:0] in_step_reg;
    logic [PROD_W-1:0] in_inc_prod_reg;
    logic [PROD_W-1:0] in_dec_prod_reg;

    always_ff @(posedge aclk) begin
        if (load_in) begin
            in_active_reg   <= s_column_active;
            in_met_reg      <= met;
            in_step_reg     <= s_step_count;
            in_inc_prod_reg <= PROD_W'(s_max_neighbor_duty) * PROD_W'(cfg_reg.increase_threshold);
            in_dec_prod_reg <= PROD_W'(s_max_neighbor_duty) * PROD_W'(cfg_reg.decrease_threshold);
        end
    end

    // ------------------------------------------------------------------
    // Column state. It doubles as the result payload: it only changes
    // when a beat moves into the result stage, which cannot happen while
    // a result is still waiting.
    // ------------------------------------------------------------------
    logic [DUTY_W-1:0]  slow_reg;
    logic [DUTY_W-1:0]  fast_reg;
    logic [DUTY_W-1:0]  ovl_reg;
    logic [BOOST_W-1:0] boost_reg;
    logic [STEP_W-1:0]  last_step_reg;
    cdbc_flags_t        flags_reg;

    logic [DUTY_W-1:0]  slow_next;
    logic [DUTY_W-1:0]  fast_next;
    logic [DUTY_W-1:0]  ovl_next;
    logic [BOOST_W-1:0] boost_next;
    logic [STEP_W-1:0]  last_step_next;
    cdbc_flags_t        flags_next;

    cdbc_ema u_ema_slow (
        .old_duty (slow_reg),
        .alpha    (cfg_reg.ema_alpha),
        .hit      (in_active_reg),
        .new_duty (slow_next)
    );

    cdbc_ema u_ema_fast (
        .old_duty (fast_reg),
        .alpha    (cfg_reg.fast_ema_alpha),
        .hit      (in_active_reg),
        .new_duty (fast_next)
    );

    // overlap duty uses the slow weight
    cdbc_ema u_ema_ovl (
        .old_duty (ovl_reg),
        .alpha    (cfg_reg.ema_alpha),
        .hit      (in_met_reg),
        .new_duty (ovl_next)
    );

    cdbc_boost u_boost (
        .cfg           (cfg_reg),
        .boost_old     (boost_reg),
        .last_step_old (last_step_reg),
        .step          (in_step_reg),
        .slow_new      (slow_next),
        .fast_new      (fast_next),
        .inc_prod      (in_inc_prod_reg),
        .dec_prod      (in_dec_prod_reg),
        .boost_new     (boost_next),
        .last_step_new (last_step_next),
        .flags         (flags_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slow_reg      <= DUTY_ONE;
            fast_reg      <= DUTY_ONE;
            ovl_reg       <= DUTY_ONE;
            boost_reg     <= BOOST_ONE;
            last_step_reg <= '0;
        end else if (move) begin
            slow_reg      <= slow_next;
            fast_reg      <= fast_next;
            ovl_reg       <= ovl_next;
            boost_reg     <= boost_next;
            last_step_reg <= last_step_next;
        end
    end

    // flags are payload only; hold them with the beat
    always_ff @(posedge aclk) begin
        if (move) begin
            flags_reg <= flags_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_active_duty       = slow_reg;
    assign m_fast_active_duty  = fast_reg;
    assign m_overlap_duty      = ovl_reg;
    assign m_boost_value       = boost_reg;
    assign m_clamp_connected   = flags_reg.clamp;
    assign m_nudge_permanences = flags_reg.nudge;

endmodule

FILE: rtl/cdbc_checker.sv
// Port-level checks for the column duty-cycle and boost controller.
// Depends on cdbc_pkg; bound to the top level at the end of this file.
module cdbc_checker import cdbc_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [DUTY_W-1:0]  m_active_duty,
    input logic [DUTY_W-1:0]  m_fast_active_duty,
    input logic [DUTY_W-1:0]  m_overlap_duty,
    input logic [BOOST_W-1:0] m_boost_value,
    input logic               m_clamp_connected,
    input logic               m_nudge_permanences
);

    // reset empties the result stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result beat holds its boost, active duty and overlap duty
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_boost_value)
                                && $stable(m_active_duty) && $stable(m_overlap_duty))
        else $error("stalled result beat changed");

    // input backpressure only comes from a full, stalled pipeline
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while result side is free");

    // duty cycles never exceed 1.0
    a_duty_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_active_duty <= DUTY_ONE) && (m_fast_active_duty <= DUTY_ONE)
                    && (m_overlap_duty <= DUTY_ONE))
        else $error("duty cycle above 1.0");

    // a step either raises boost or finds it capped, never both
    a_flags_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_clamp_connected && m_nudge_permanences))
        else $error("clamp and nudge requested together");

endmodule

bind column_duty_cycle_boost_controller cdbc_checker u_cdbc_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_active_duty       (m_active_duty),
    .m_fast_active_duty  (m_fast_active_duty),
    .m_overlap_duty      (m_overlap_duty),
    .m_boost_value       (m_boost_value),
    .m_clamp_connected   (m_clamp_connected),
    .m_nudge_permanences (m_nudge_permanences)
);
